// ----- hdl/stb_pkg.sv -----
package stb_pkg;

  localparam int NumTimers = 8;
  localparam int IdxW      = 3;
  localparam int TimeW     = 32;
  localparam int OpW       = 3;

  localparam logic [OpW-1:0] OpTick  = 3'd0;
  localparam logic [OpW-1:0] OpInit  = 3'd1;
  localparam logic [OpW-1:0] OpStart = 3'd2;
  localparam logic [OpW-1:0] OpStop  = 3'd3;
  localparam logic [OpW-1:0] OpReset = 3'd4;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [IdxW-1:0]  timer_index;
    logic [TimeW-1:0] timeout_ticks;
    logic             auto_reload;
  } in_item_t;

  typedef struct packed {
    logic            fired;
    logic [IdxW-1:0] fired_index;
    logic            last;
  } out_item_t;

  typedef enum logic [2:0] {
    CmdTick,
    CmdInit,
    CmdStart,
    CmdStop,
    CmdReset,
    CmdNop
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [IdxW-1:0]  idx;
    logic [TimeW-1:0] timeout;
    logic             periodic;
  } cmd_t;

endpackage

// ----- hdl/stb_front.sv -----
module stb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  stb_pkg::in_item_t in_item_i,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i,
  output stb_pkg::cmd_t    cmd_o
);

  stb_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  stb_pkg::cmd_t cmd_in;
  logic          push;
  logic          pop;
  logic          in_range;

  // Decode the opcode once so the back end only sees what it must do.
  always_comb begin
    in_range        = ({29'b0, in_item_i.timer_index} < 32'(stb_pkg::NumTimers));
    cmd_in.idx      = in_item_i.timer_index;
    cmd_in.timeout  = in_item_i.timeout_ticks;
    cmd_in.periodic = in_item_i.auto_reload;
    cmd_in.kind     = stb_pkg::CmdNop;
    case (in_item_i.opcode)
      stb_pkg::OpTick:  cmd_in.kind = stb_pkg::CmdTick;
      stb_pkg::OpInit:  if (in_range) cmd_in.kind = stb_pkg::CmdInit;
      stb_pkg::OpStart: if (in_range) cmd_in.kind = stb_pkg::CmdStart;
      stb_pkg::OpStop:  if (in_range) cmd_in.kind = stb_pkg::CmdStop;
      stb_pkg::OpReset: if (in_range) cmd_in.kind = stb_pkg::CmdReset;
      default:          cmd_in.kind = stb_pkg::CmdNop;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- hdl/stb_back.sv -----
module stb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  stb_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stb_pkg::out_item_t out_item_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StWalk   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [stb_pkg::IdxW-1:0]      walk_q, walk_d;
  logic                          pend_v_q, pend_v_d;
  logic [stb_pkg::IdxW-1:0]      pend_idx_q, pend_idx_d;
  logic                          out_valid_q, out_valid_d;
  stb_pkg::out_item_t            out_q, out_d;

  logic [stb_pkg::NumTimers-1:0] registered_q, registered_d;
  logic [stb_pkg::NumTimers-1:0] active_q, active_d;
  logic [stb_pkg::NumTimers-1:0] periodic_q, periodic_d;
  logic [stb_pkg::TimeW-1:0]     timeout_q [stb_pkg::NumTimers];
  logic [stb_pkg::TimeW-1:0]     elapsed_q [stb_pkg::NumTimers];

  logic                          can_emit;
  logic                          emit;
  stb_pkg::out_item_t            emit_item;
  logic [stb_pkg::IdxW-1:0]      addr;
  logic [stb_pkg::TimeW-1:0]     elapsed_inc;
  logic                          hit;
  logic                          eligible;
  logic                          elapsed_we;
  logic [stb_pkg::TimeW-1:0]     elapsed_wdata;
  logic                          timeout_we;

  assign can_emit    = !out_valid_q || out_ready_i;
  assign addr        = (state_q == StWalk) ? walk_q : cmd_i.idx;
  assign elapsed_inc = elapsed_q[addr] + 32'd1;
  assign hit         = (elapsed_inc >= timeout_q[addr]);
  assign eligible    = registered_q[walk_q] && active_q[walk_q];

  always_comb begin
    state_d       = state_q;
    walk_d        = walk_q;
    pend_v_d      = pend_v_q;
    pend_idx_d    = pend_idx_q;
    registered_d  = registered_q;
    active_d      = active_q;
    periodic_d    = periodic_q;
    elapsed_we    = 1'b0;
    elapsed_wdata = '0;
    timeout_we    = 1'b0;
    emit          = 1'b0;
    emit_item     = '{fired: 1'b0, fired_index: '0, last: 1'b1};
    cmd_pop_o     = 1'b0;

    case (state_q)
      StIdle: begin
        if (cmd_valid_i && can_emit) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == stb_pkg::CmdTick) begin
            state_d  = StWalk;
            walk_d   = '0;
            pend_v_d = 1'b0;
          end else begin
            emit = 1'b1;
            case (cmd_i.kind)
              stb_pkg::CmdInit: begin
                registered_d[addr] = 1'b1;
                active_d[addr]     = 1'b0;
                periodic_d[addr]   = cmd_i.periodic;
                timeout_we         = 1'b1;
                elapsed_we         = 1'b1;
              end
              stb_pkg::CmdStart: begin
                active_d[addr] = 1'b1;
                elapsed_we     = 1'b1;
              end
              stb_pkg::CmdStop: begin
                active_d[addr] = 1'b0;
                elapsed_we     = 1'b1;
              end
              stb_pkg::CmdReset: begin
                elapsed_we = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
      StWalk: begin
        if (can_emit) begin
          if (eligible) begin
            elapsed_we    = 1'b1;
            elapsed_wdata = hit ? '0 : elapsed_inc;
            if (hit) begin
              if (!periodic_q[walk_q]) begin
                active_d[walk_q] = 1'b0;
              end
              // A firing slot is held in the pending register so the final one can carry last.
              if (pend_v_q) begin
                emit      = 1'b1;
                emit_item = '{fired: 1'b1, fired_index: pend_idx_q, last: 1'b0};
              end
              pend_v_d   = 1'b1;
              pend_idx_d = walk_q;
            end
          end
          if (walk_q == stb_pkg::IdxW'(stb_pkg::NumTimers - 1)) begin
            state_d = StFinish;
          end else begin
            walk_d = walk_q + stb_pkg::IdxW'(1);
          end
        end
      end
      StFinish: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_item = '{fired: pend_v_q, fired_index: pend_v_q ? pend_idx_q : '0, last: 1'b1};
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      walk_q       <= '0;
      pend_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      registered_q <= '0;
      active_q     <= '0;
      periodic_q   <= '0;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      pend_v_q     <= pend_v_d;
      out_valid_q  <= out_valid_d;
      registered_q <= registered_d;
      active_q     <= active_d;
      periodic_q   <= periodic_d;
    end
  end

  // Counts and timeouts are only read after an init has written them.
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    out_q      <= out_d;
    if (elapsed_we) begin
      elapsed_q[addr] <= elapsed_wdata;
    end
    if (timeout_we) begin
      timeout_q[addr] <= cmd_i.timeout;
    end
  end

endmodule

// ----- hdl/software_timer_bank_top.sv -----
// Bank of eight software timers driven by one command per input beat.
// The input channel (in_valid_i / in_ready_o / in_item_i) carries an opcode:
// tick, init, start, stop or reset, with a slot index, timeout and reload mode.
// The output channel (out_valid_o / out_ready_i / out_item_o) returns one beat
// per firing slot for a tick, in slot order, with last set on the final beat;
// any command that fires nothing returns a single non-firing beat with last set.
// A two-entry command queue sits between the decoder and the execution unit,
// so the input keeps taking beats while the execution unit works or stalls.
// A non-tick command is written into the queue, then executed in the idle
// state with its result registered in the output register. A tick is dequeued
// in the idle state, then walks the slots (the single timer count read/update
// port visits one slot per cycle unless the output stalls), then a finish
// state sends the final beat; the next command is taken only after that state.
// Reset clears all slots to unregistered and inactive and empties the queue.
// When the receiver holds out_ready_i low the execution unit freezes in place
// and the queue fills; in_ready_o falls once the queue is full.
module software_timer_bank_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stb_pkg::out_item_t out_item_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  stb_pkg::cmd_t cmd;

  stb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  stb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- bench/tb_software_timer_bank_top.sv -----
`timescale 1ns / 1ps

module tb_software_timer_bank_top;

  localparam logic [stb_pkg::OpW-1:0] OpSpareLo = 3'd5;
  localparam logic [stb_pkg::OpW-1:0] OpSpareHi = 3'd7;
  localparam int RandomItems = 400;
  localparam int HoldAfter   = 120;
  localparam int HoldCycles  = 400;
  localparam int QuietTail   = 60;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 200000;
  localparam int MaxReported = 10;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  stb_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  stb_pkg::out_item_t out_item;

  software_timer_bank_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the timer bank.
  bit          slot_known   [stb_pkg::NumTimers];
  bit          slot_running [stb_pkg::NumTimers];
  bit          slot_periodic[stb_pkg::NumTimers];
  logic [31:0] slot_limit   [stb_pkg::NumTimers];
  logic [31:0] slot_count   [stb_pkg::NumTimers];

  stb_pkg::in_item_t  pending_cmds[$];
  stb_pkg::out_item_t expected_beats[$];

  int  total_cmds;
  int  accepted_count;
  int  beats_checked;
  int  firing_beats;
  int  ticks_seen;
  int  most_fires;
  int  mismatch_count;
  int  cycle_count;
  bit  in_taken;
  bit  idle_on;
  int  in_gap;
  int  out_gap;
  int  hold_left;
  bit  hold_done;

  function automatic stb_pkg::in_item_t timer_cmd(logic [stb_pkg::OpW-1:0] op,
                                                  int unsigned idx,
                                                  logic [stb_pkg::TimeW-1:0] tmo,
                                                  logic rel);
    stb_pkg::in_item_t c;
    c.opcode        = op;
    c.timer_index   = idx[stb_pkg::IdxW-1:0];
    c.timeout_ticks = tmo;
    c.auto_reload   = rel;
    return c;
  endfunction

  function automatic void enqueue_cmd(stb_pkg::in_item_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  // Updates the shadow bank for one accepted command and queues the beats it causes.
  task automatic apply_timer_command(stb_pkg::in_item_t cmd);
    stb_pkg::out_item_t beat;
    int                 fires;
    int                 slot;
    fires = 0;
    slot  = int'(cmd.timer_index);
    if (cmd.opcode == stb_pkg::OpTick) begin
      ticks_seen++;
      for (int i = 0; i < stb_pkg::NumTimers; i++) begin
        if (slot_known[i] && slot_running[i]) begin
          slot_count[i] = slot_count[i] + 32'd1;
          if (slot_count[i] >= slot_limit[i]) begin
            slot_count[i] = '0;
            if (!slot_periodic[i]) slot_running[i] = 1'b0;
            beat.fired       = 1'b1;
            beat.fired_index = i[stb_pkg::IdxW-1:0];
            beat.last        = 1'b0;
            expected_beats = {expected_beats, beat};
            fires++;
          end
        end
      end
      if (fires > most_fires) most_fires = fires;
      if (fires > 0) begin
        expected_beats[$].last = 1'b1;
        return;
      end
    end else if (slot < stb_pkg::NumTimers) begin
      case (cmd.opcode)
        stb_pkg::OpInit: begin
          slot_known[slot]    = 1'b1;
          slot_limit[slot]    = cmd.timeout_ticks;
          slot_count[slot]    = '0;
          slot_running[slot]  = 1'b0;
          slot_periodic[slot] = cmd.auto_reload;
        end
        stb_pkg::OpStart: begin
          slot_count[slot]   = '0;
          slot_running[slot] = 1'b1;
        end
        stb_pkg::OpStop: begin
          slot_running[slot] = 1'b0;
          slot_count[slot]   = '0;
        end
        stb_pkg::OpReset: begin
          slot_count[slot] = '0;
        end
        default: ;
      endcase
    end
    beat.fired       = 1'b0;
    beat.fired_index = '0;
    beat.last        = 1'b1;
    expected_beats = {expected_beats, beat};
  endtask

  function automatic void note_mismatch(string what, stb_pkg::out_item_t want,
                                        stb_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("[%0t] %s: expected fired=%0b index=%0d last=%0b, got fired=%0b index=%0d last=%0b",
               $time, what, want.fired, want.fired_index, want.last,
               got.fired, got.fired_index, got.last);
    end
  endfunction

  // Sample side: accepted input beats feed the shadow bank, output beats are checked.
  always @(posedge clk_i) begin
    stb_pkg::out_item_t want;
    in_taken = rst_ni && in_valid && in_ready;
    if (in_taken) begin
      apply_timer_command(in_item);
      accepted_count++;
    end
    if (rst_ni && out_valid && out_ready) begin
      beats_checked++;
      if (out_item.fired === 1'b1) firing_beats++;
      if (expected_beats.size() == 0) begin
        note_mismatch("unexpected beat", '0, out_item);
      end else begin
        want = expected_beats.pop_front();
        if (out_item.fired !== want.fired || out_item.fired_index !== want.fired_index ||
            out_item.last !== want.last) begin
          note_mismatch("beat mismatch", want, out_item);
        end
      end
    end
    idle_on = (total_cmds - accepted_count) > QuietTail;
  end

  // Command driver.
  always @(negedge clk_i) begin
    logic              nxt_valid;
    stb_pkg::in_item_t nxt_item;
    nxt_valid = in_valid;
    nxt_item  = in_item;
    if (rst_ni && (!in_valid || in_taken)) begin
      nxt_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_cmds.size() != 0) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 6) - 1;
        end else begin
          nxt_valid = 1'b1;
          nxt_item  = pending_cmds.pop_front();
        end
      end
    end
    in_valid <= nxt_valid;
    in_item  <= nxt_item;
  end

  // Result receiver, with one long hold-off so the command queue backs up.
  always @(negedge clk_i) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (!hold_done && accepted_count >= HoldAfter) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (!rst_ni) begin
      nxt_ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      nxt_ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_gap   = $urandom_range(1, 6) - 1;
      nxt_ready = 1'b0;
    end
    out_ready <= nxt_ready;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_beats.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int           made;
    int unsigned  pick;
    int unsigned  idx;
    logic [31:0]  tmo;

    // Directed opening: zero timeout, one-shot vs periodic, all-ones timeout,
    // commands on a slot that was never set up, re-init, and spare opcodes.
    enqueue_cmd(timer_cmd(stb_pkg::OpInit, 0, 32'd0, 1'b1));
    enqueue_cmd(timer_cmd(stb_pkg::OpStart, 0, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpTick, 0, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpInit, 1, 32'd1, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpStart, 1, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpTick, 0, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpTick, 0, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpInit, 7, 32'hFFFF_FFFF, 1'b1));
    enqueue_cmd(timer_cmd(stb_pkg::OpStart, 7, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpStart, 3, 32'hFFFF_FFFF, 1'b1));
    enqueue_cmd(timer_cmd(stb_pkg::OpTick, 7, 32'hFFFF_FFFF, 1'b1));
    enqueue_cmd(timer_cmd(stb_pkg::OpReset, 7, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpStop, 0, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpTick, 0, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpInit, 0, 32'd2, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpStart, 0, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpTick, 0, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpTick, 0, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpStop, 3, 32'd0, 1'b0));
    enqueue_cmd(timer_cmd(stb_pkg::OpReset, 3, 32'd0, 1'b0));
    for (int op = OpSpareLo; op <= OpSpareHi; op++) begin
      enqueue_cmd(timer_cmd(op[stb_pkg::OpW-1:0], $urandom_range(0, 7), $urandom(),
                            1'($urandom_range(0, 1))));
    end
    enqueue_cmd(timer_cmd(stb_pkg::OpInit, 7, 32'd0, 1'b1));
    enqueue_cmd(timer_cmd(stb_pkg::OpTick, 0, 32'd0, 1'b0));

    made = 0;
    while (made < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // Arm the whole bank with short timeouts so one tick fires every slot.
        for (int i = 0; i < stb_pkg::NumTimers; i++) begin
          enqueue_cmd(timer_cmd(stb_pkg::OpInit, i, $urandom_range(0, 1),
                                1'($urandom_range(0, 1))));
          enqueue_cmd(timer_cmd(stb_pkg::OpStart, i, $urandom(), 1'b0));
        end
        made += 2 * stb_pkg::NumTimers;
      end else begin
        idx = $urandom_range(0, stb_pkg::NumTimers - 1);
        tmo = ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 5)) : 32'($urandom());
        if (pick < 50) begin
          enqueue_cmd(timer_cmd(stb_pkg::OpTick, idx, tmo, 1'($urandom_range(0, 1))));
        end else if (pick < 65) begin
          enqueue_cmd(timer_cmd(stb_pkg::OpInit, idx, tmo, 1'($urandom_range(0, 1))));
        end else if (pick < 80) begin
          enqueue_cmd(timer_cmd(stb_pkg::OpStart, idx, tmo, 1'($urandom_range(0, 1))));
        end else if (pick < 88) begin
          enqueue_cmd(timer_cmd(stb_pkg::OpStop, idx, tmo, 1'($urandom_range(0, 1))));
        end else if (pick < 96) begin
          enqueue_cmd(timer_cmd(stb_pkg::OpReset, idx, tmo, 1'($urandom_range(0, 1))));
        end else begin
          enqueue_cmd(timer_cmd(stb_pkg::OpW'($urandom_range(OpSpareLo, OpSpareHi)), idx,
                                $urandom(), 1'($urandom_range(0, 1))));
        end
        made++;
      end
    end
    total_cmds = pending_cmds.size();
    idle_on    = 1'b1;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_count != total_cmds || expected_beats.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (DrainCycles) @(posedge clk_i);
    #1;

    $display("Sent %0d commands (%0d ticks); checked %0d result beats, %0d of them firing.",
             accepted_count, ticks_seen, beats_checked, firing_beats);
    $display("Most slots fired by one tick: %0d; one long output stall backed up the input.",
             most_fires);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d beats never arrived", mismatch_count,
               expected_beats.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
